// ===== sv/asrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive spike reject filter package
// Shared widths, constants, decision codes and the threshold factor table.
// ----------------------------------------------------------------------------
package asrf_pkg;

  localparam int unsigned RawW  = 16;  // raw reading, two's complement
  localparam int unsigned ValW  = 15;  // in-range level, percent * 256
  localparam int unsigned DecW  = 3;   // decision code
  localparam int unsigned RcW   = 5;   // saturating reading count
  localparam int unsigned RunW  = 4;   // run of large steps
  localparam int unsigned FacW  = 6;   // threshold factor (threshold * 20 / base)
  localparam int unsigned T20W  = 21;  // threshold * 20
  localparam int unsigned T60W  = 23;  // threshold * 60 (1.5 times, scaled by 40)
  localparam int unsigned SumW  = 18;  // 7 * new + 3 * prior + 5
  localparam int unsigned RecW  = 19;  // reciprocal of ten
  localparam int unsigned ProdW = SumW + RecW;

  localparam logic [ValW-1:0] FullScale   = 15'd25600;
  localparam logic [ValW-1:0] BaseReset   = 15'd1280;
  localparam logic [RunW-1:0] RecalRun    = 4'd8;
  localparam logic [RcW-1:0]  CountMax    = 5'd31;
  localparam logic [RcW-1:0]  EarlyEnd    = 5'd10;
  localparam logic [RcW-1:0]  SlideEnd    = 5'd30;
  localparam logic [RcW-1:0]  VoteSwitch  = 5'd20;
  localparam logic [FacW-1:0] EarlyFactor = 6'd60;
  localparam logic [FacW-1:0] SlideBase   = 6'd50;
  localparam logic [FacW-1:0] LateFactor  = 6'd20;
  localparam logic [T20W-1:0] StepScale   = 21'd20;
  localparam logic [T60W-1:0] ConfScale   = 23'd40;
  localparam logic [T60W-1:0] ConfThrMul  = 23'd3;
  localparam logic [SumW-1:0] NewWeight   = 18'd7;
  localparam logic [SumW-1:0] PriorWeight = 18'd3;
  localparam logic [SumW-1:0] RoundBias   = 18'd5;
  // floor(x / 10) == (x * 419431) >> 22 for every x below 2^18.
  localparam logic [RecW-1:0] DivTenRecip = 19'd419431;
  localparam int unsigned     DivTenShift = 22;

  typedef enum logic [DecW-1:0] {
    DEC_RANGE   = 3'd0,
    DEC_FIRST   = 3'd1,
    DEC_SMALL   = 3'd2,
    DEC_RECAL   = 3'd3,
    DEC_NO_HIST = 3'd4,
    DEC_CONFIRM = 3'd5,
    DEC_REJECT  = 3'd6
  } decision_e;

  // Threshold times 20, divided by the base, for a given reading count.
  function automatic logic [FacW-1:0] thr_factor(input logic [RcW-1:0] count);
    logic [FacW-1:0] fac;
    if (count <= EarlyEnd) begin
      fac = EarlyFactor;
    end else if (count <= SlideEnd) begin
      fac = SlideBase - FacW'(count);
    end else begin
      fac = LateFactor;
    end
    return fac;
  endfunction

  // Saturating increment of the reading count.
  function automatic logic [RcW-1:0] count_inc(input logic [RcW-1:0] count);
    return (count == CountMax) ? CountMax : count + RcW'(1);
  endfunction

endpackage

// ===== sv/asrf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive spike reject filter input channel
// Valid/ready channel that carries one raw level reading per request.
// ----------------------------------------------------------------------------
interface asrf_in_if;
  import asrf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [RawW-1:0] raw_percent;

  modport source (output valid, output raw_percent, input ready);
  modport sink   (input valid, input raw_percent, output ready);
endinterface

// ===== sv/asrf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive spike reject filter output channel
// Valid/ready channel that carries the filtered level and its decision code.
// ----------------------------------------------------------------------------
interface asrf_out_if;
  import asrf_pkg::*;

  logic            valid;
  logic            ready;
  logic [ValW-1:0] filtered_percent;
  logic [DecW-1:0] decision;

  modport source (output valid, output filtered_percent, output decision, input ready);
  modport sink   (input valid, input filtered_percent, input decision, output ready);
endinterface

// ===== sv/asrf_confirm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive spike reject filter confirmation vote
// Counts history entries near a new reading and decides whether a large step
// has enough support to be accepted.
// ----------------------------------------------------------------------------
module asrf_confirm #(
  parameter int unsigned DEPTH = 5
) (
  input  logic [asrf_pkg::ValW-1:0] hist_i [DEPTH],
  input  logic [$clog2(DEPTH+1)-1:0] cnt_i,
  input  logic [asrf_pkg::ValW-1:0] value_i,
  input  logic [asrf_pkg::T60W-1:0] thr60_i,
  input  logic                      late_i,
  output logic                      ok_o
);
  import asrf_pkg::*;

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned VoteW = CntW + 3;

  logic [DEPTH-1:0] near;
  logic [CntW-1:0]  conf;
  logic [VoteW-1:0] conf5;
  logic [VoteW-1:0] need;

  always_comb begin
    logic [ValW-1:0] dif;
    logic [T60W-1:0] scaled;
    for (int i = 0; i < DEPTH; i++) begin
      dif     = (hist_i[i] > value_i) ? hist_i[i] - value_i : value_i - hist_i[i];
      scaled  = T60W'(dif) * ConfScale;
      near[i] = (CntW'(i) < cnt_i) && (scaled <= thr60_i);
    end
  end

  assign conf  = CntW'($countones(near));
  assign conf5 = (VoteW'(conf) << 2) + VoteW'(conf);
  // Later in the run a large step needs twice the support.
  assign need  = late_i ? (VoteW'(cnt_i) << 1) : VoteW'(cnt_i);
  assign ok_o  = (conf5 >= need);

endmodule

// ===== sv/adaptive_spike_reject_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive spike reject filter unit
// Filters tank level readings: rejects out-of-range values and spikes,
// smooths small steps and confirms large steps against a short history.
// ----------------------------------------------------------------------------
// A request waits in the single input register until the result register is free
// or being emptied, then moves through one pass of filter logic into the result
// register, which drives the output. Throughput: one request per cycle while the
// output does not stall; all state updates as the result register is loaded.
// Reset clears all control state and the filter state, loads the base
// threshold with 1280 and the factor with 60; history entries are not cleared.
// ----------------------------------------------------------------------------
module adaptive_spike_reject_filter_unit #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [asrf_pkg::ValW-1:0] cfg_wdata_i,
  asrf_in_if.sink                   in_req_i,
  asrf_out_if.source                out_rsp_o
);
  import asrf_pkg::*;

  localparam int unsigned SlotW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(HISTORY_DEPTH);
  localparam logic [CntW-1:0]  MinHist  = CntW'(2);

  // Input register. A request waits here for one pass through the filter logic.
  logic            in_vld_q;
  logic [RawW-1:0] raw_q;

  // Result register.
  logic            out_vld_q;
  logic [ValW-1:0] filt_q, filt_d;
  decision_e       dec_q, dec_d;

  // Filter state. The history entries carry no reset: only the first
  // hist_cnt_q entries are ever looked at, and those have been written.
  logic [ValW-1:0]  base_q;
  logic [FacW-1:0]  fac_q, fac_d;
  logic [ValW-1:0]  hist_q [HISTORY_DEPTH];
  logic [SlotW-1:0] slot_q, slot_d;
  logic [CntW-1:0]  hist_cnt_q, hist_cnt_d;
  logic             have_last_q, have_last_d;
  logic [ValW-1:0]  last_q, last_d;
  logic [RcW-1:0]   rc_q, rc_d;
  logic [RunW-1:0]  run_q, run_d;

  logic hist_wr;   // store the reading at the write slot
  logic hist_fill; // refill every entry with the reading
  logic advance;

  // The request in the input register moves on whenever the result register
  // is free or is being emptied in this cycle.
  assign advance        = in_vld_q && (!out_vld_q || out_rsp_o.ready);
  assign in_req_i.ready = !in_vld_q || advance;

  assign out_rsp_o.valid            = out_vld_q;
  assign out_rsp_o.filtered_percent = filt_q;
  assign out_rsp_o.decision         = dec_q;

  // ---------------------------------------------------------------------------
  // Filter datapath.
  // ---------------------------------------------------------------------------
  logic [RcW-1:0]   rc_inc;
  logic [T20W-1:0]  t20;
  logic [T60W-1:0]  thr60;
  logic             in_range;
  logic [ValW-1:0]  val;
  logic [ValW-1:0]  diff;
  logic [T20W-1:0]  diff20;
  logic             small_step;
  logic [RunW-1:0]  run_inc;
  logic             late;
  logic             conf_ok;
  logic [SumW-1:0]  blend_sum;
  logic [ProdW-1:0] blend_prod;
  logic [ValW-1:0]  blend;

  assign rc_inc = count_inc(rc_q);

  // The threshold factor for this request was prepared from the previous
  // reading count, so only the base multiply sits in front of the compares.
  assign t20   = T20W'(base_q) * T20W'(fac_q);
  assign thr60 = T60W'(t20) * ConfThrMul;

  // Negative readings look like huge unsigned values and fall out here too.
  assign in_range = (raw_q <= RawW'(FullScale));
  assign val      = raw_q[ValW-1:0];
  assign diff     = (val > last_q) ? val - last_q : last_q - val;
  assign diff20   = T20W'(diff) * StepScale;
  assign small_step = (diff20 <= t20);

  assign run_inc = run_q + RunW'(1);
  assign late    = (rc_inc > VoteSwitch);

  // 0.7 * new + 0.3 * prior, rounded half up; the divide by ten is a
  // reciprocal multiply.
  assign blend_sum  = NewWeight * SumW'(val) + PriorWeight * SumW'(last_q) + RoundBias;
  assign blend_prod = ProdW'(blend_sum) * ProdW'(DivTenRecip);
  assign blend      = blend_prod[DivTenShift +: ValW];

  asrf_confirm #(
    .DEPTH (HISTORY_DEPTH)
  ) u_confirm (
    .hist_i  (hist_q),
    .cnt_i   (hist_cnt_q),
    .value_i (val),
    .thr60_i (thr60),
    .late_i  (late),
    .ok_o    (conf_ok)
  );

  // ---------------------------------------------------------------------------
  // Decision and next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    slot_d      = slot_q;
    hist_cnt_d  = hist_cnt_q;
    have_last_d = have_last_q;
    last_d      = last_q;
    rc_d        = rc_q;
    run_d       = run_q;
    hist_wr     = 1'b0;
    hist_fill   = 1'b0;
    filt_d      = last_q;
    dec_d       = DEC_RANGE;

    if (advance) begin
      rc_d = rc_inc;
      if (!in_range) begin
        // Out-of-range readings only advance the reading count.
        filt_d = last_q;
        dec_d  = DEC_RANGE;
      end else if (!have_last_q) begin
        hist_wr = 1'b1;
        filt_d  = val;
        dec_d   = DEC_FIRST;
      end else if (small_step) begin
        hist_wr = 1'b1;
        run_d   = '0;
        filt_d  = blend;
        dec_d   = DEC_SMALL;
      end else begin
        run_d = run_inc;
        if (run_inc >= RecalRun) begin
          // Too many large steps in a row: the level really moved, so the
          // history restarts from this reading.
          hist_fill   = 1'b1;
          slot_d      = '0;
          hist_cnt_d  = FullCnt;
          last_d      = val;
          have_last_d = 1'b1;
          run_d       = '0;
          rc_d        = RcW'(1);
          filt_d      = val;
          dec_d       = DEC_RECAL;
        end else if (hist_cnt_q < MinHist) begin
          filt_d = last_q;
          dec_d  = DEC_NO_HIST;
        end else if (conf_ok) begin
          hist_wr = 1'b1;
          run_d   = '0;
          filt_d  = val;
          dec_d   = DEC_CONFIRM;
        end else begin
          filt_d = last_q;
          dec_d  = DEC_REJECT;
        end
      end

      if (hist_wr) begin
        slot_d      = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
        hist_cnt_d  = (hist_cnt_q == FullCnt) ? FullCnt : hist_cnt_q + CntW'(1);
        last_d      = val;
        have_last_d = 1'b1;
      end
    end

    // Factor for the next request, from the count it will see after its own
    // increment.
    fac_d = thr_factor(count_inc(rc_d));
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      base_q      <= BaseReset;
      fac_q       <= EarlyFactor;
      slot_q      <= '0;
      hist_cnt_q  <= '0;
      have_last_q <= 1'b0;
      last_q      <= '0;
      rc_q        <= '0;
      run_q       <= '0;
    end else begin
      if (in_req_i.ready) begin
        in_vld_q <= in_req_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      fac_q       <= fac_d;
      slot_q      <= slot_d;
      hist_cnt_q  <= hist_cnt_d;
      have_last_q <= have_last_d;
      last_q      <= last_d;
      rc_q        <= rc_d;
      run_q       <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req_i.valid && in_req_i.ready) begin
      raw_q <= in_req_i.raw_percent;
    end
    if (advance) begin
      filt_q <= filt_d;
      dec_q  <= dec_d;
    end
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_fill || (hist_wr && (slot_q == SlotW'(i)))) begin
        hist_q[i] <= val;
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike reject filter regression bench
// Sends level readings through the filter and checks the filtered level and
// the decision code of every result. The expected values come from a
// behavioral copy of the filter that runs alongside the block. The run starts
// with a short hand-written table of readings at the reset threshold. It then
// goes through several base threshold settings, the two extremes among them,
// with random readings shaped to reach smoothing, confirmation, rejection and
// recalibration. Both channels stall at random, except in the last setting.
// ----------------------------------------------------------------------------
module testbench;
  import asrf_pkg::*;

  localparam int unsigned HistDepth     = 5;
  localparam int unsigned NumProbes     = 23;
  localparam int unsigned NumPhases     = 7;
  localparam int unsigned PhaseItems    = 80;
  localparam int unsigned SettleCycles  = 3;
  localparam int unsigned WatchdogLimit = 1000;

  // One filter result: the level shown on the output and why it was chosen.
  typedef struct packed {
    logic [ValW-1:0] level;
    decision_e       dec;
  } level_result_t;

  // One row of the hand-written table. When typed is set, the expected result
  // is the one in the row. Otherwise the behavioral filter supplies it.
  typedef struct packed {
    logic [RawW-1:0] raw;
    logic            typed;
    logic [ValW-1:0] level;
    decision_e       dec;
  } probe_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [ValW-1:0] cfg_wdata;

  asrf_in_if  in_req ();
  asrf_out_if out_rsp ();

  adaptive_spike_reject_filter_unit #(
    .HISTORY_DEPTH(HistDepth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_req_i   (in_req),
    .out_rsp_o  (out_rsp)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioral copy of the filter state. It is advanced once for every request
  // that the block accepts, in the order of acceptance.
  // --------------------------------------------------------------------------
  logic [ValW-1:0] thr_base   = BaseReset;
  logic [ValW-1:0] hist_mem [HistDepth];
  logic [2:0]      hist_slot  = '0;
  logic [2:0]      hist_fill  = '0;
  logic            seen_level = 1'b0;
  logic [ValW-1:0] last_level = '0;
  logic [RcW-1:0]  read_cnt   = '0;
  logic [RunW-1:0] spike_run  = '0;

  level_result_t pending_levels [$];
  level_result_t due;

  int unsigned dec_seen [7];
  int unsigned error_count     = 0;
  int unsigned readings_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 1;
  int unsigned quiet_cycles    = 0;
  int unsigned ready_hold      = 0;
  bit          idling_on       = 1'b0;

  // A run of far readings that repeats one level, which is how the stimulus
  // reaches recalibration.
  logic [RawW-1:0] burst_level = '0;
  int unsigned     burst_left  = 0;

  // Hand-written readings at the reset threshold of 1280. Out-of-range
  // patterns come first, so that the output still shows zero. Then the first
  // reading, a far step with only one history entry, a step exactly at three
  // times the base, a confirmed jump and eight spikes in a row that force a
  // refill of the history.
  probe_row_t probe_rows [NumProbes] = '{
    '{16'hFFFF, 1'b1, 15'd0,     DEC_RANGE},
    '{16'd25601, 1'b1, 15'd0,    DEC_RANGE},
    '{16'h8000, 1'b1, 15'd0,     DEC_RANGE},
    '{16'h7FFF, 1'b1, 15'd0,     DEC_RANGE},
    '{16'd0,     1'b1, 15'd0,    DEC_FIRST},
    '{16'd25600, 1'b1, 15'd0,    DEC_NO_HIST},
    '{16'd3840,  1'b0, 15'd0,    DEC_RANGE},
    '{16'd7681,  1'b0, 15'd0,    DEC_RANGE},
    '{16'd7700,  1'b0, 15'd0,    DEC_RANGE},
    '{16'd7690,  1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd20000, 1'b1, 15'd20000, DEC_RECAL},
    '{16'd20100, 1'b0, 15'd0,    DEC_RANGE},
    '{16'hFFFB, 1'b0, 15'd0,     DEC_RANGE},
    '{16'd25600, 1'b0, 15'd0,    DEC_RANGE},
    '{16'd0,     1'b0, 15'd0,    DEC_RANGE},
    '{16'd25599, 1'b0, 15'd0,    DEC_RANGE}
  };

  // Allowed step times 20 for a given reading count. The value is three times
  // the base early on, then it slides down to the base itself.
  function automatic int unsigned step_limit_x20(input logic [RcW-1:0] count);
    if (count <= 5'd10) begin
      return thr_base * 60;
    end else if (count <= 5'd30) begin
      return thr_base * (50 - count);
    end
    return thr_base * 20;
  endfunction

  function automatic int unsigned level_gap(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [RawW-1:0] clamp_level(input int v);
    if (v < 0) begin
      return '0;
    end else if (v > 25600) begin
      return 16'd25600;
    end
    return RawW'(v);
  endfunction

  // Take a reading into the history and make it the last accepted level.
  function automatic void keep_level(input logic [ValW-1:0] v);
    hist_mem[hist_slot] = v;
    hist_slot = (hist_slot == 3'(HistDepth - 1)) ? 3'd0 : hist_slot + 3'd1;
    if (hist_fill < 3'(HistDepth)) begin
      hist_fill = hist_fill + 3'd1;
    end
    last_level = v;
    seen_level = 1'b1;
  endfunction

  // Advance the behavioral filter by one reading and return its result.
  function automatic level_result_t predict_level(input logic [RawW-1:0] raw);
    int unsigned     t20;
    int unsigned     conf;
    int unsigned     lvl_u;
    int unsigned     prev;
    bit              agreed;
    logic [ValW-1:0] lvl;
    level_result_t   r;
    lvl   = raw[ValW-1:0];
    lvl_u = lvl;
    if (read_cnt != 5'd31) begin
      read_cnt = read_cnt + 5'd1;
    end
    t20 = step_limit_x20(read_cnt);
    // Every negative pattern is above full scale when it is read as unsigned.
    if (raw > 16'd25600) begin
      r.level = last_level;
      r.dec   = DEC_RANGE;
    end else if (!seen_level) begin
      keep_level(lvl);
      r.level = lvl;
      r.dec   = DEC_FIRST;
    end else if (level_gap(lvl_u, last_level) * 20 <= t20) begin
      prev = last_level;
      keep_level(lvl);
      spike_run = '0;
      r.level   = ValW'((7 * lvl_u + 3 * prev + 5) / 10);
      r.dec     = DEC_SMALL;
    end else begin
      spike_run = spike_run + 4'd1;
      if (spike_run >= 4'd8) begin
        for (int i = 0; i < HistDepth; i++) begin
          hist_mem[i] = lvl;
        end
        hist_slot  = '0;
        hist_fill  = 3'(HistDepth);
        last_level = lvl;
        seen_level = 1'b1;
        spike_run  = '0;
        read_cnt   = 5'd1;
        r.level    = lvl;
        r.dec      = DEC_RECAL;
      end else if (hist_fill < 3'd2) begin
        r.level = last_level;
        r.dec   = DEC_NO_HIST;
      end else begin
        conf = 0;
        for (int i = 0; i < int'(hist_fill); i++) begin
          if (level_gap(hist_mem[i], lvl_u) * 40 <= t20 * 3) begin
            conf++;
          end
        end
        // Early on one vote in five is enough, later it takes two in five.
        if (read_cnt <= 5'd20) begin
          agreed = (conf * 5 >= hist_fill);
        end else begin
          agreed = (conf * 5 >= 2 * hist_fill);
        end
        if (agreed) begin
          keep_level(lvl);
          spike_run = '0;
          r.level   = lvl;
          r.dec     = DEC_CONFIRM;
        end else begin
          r.level = last_level;
          r.dec   = DEC_REJECT;
        end
      end
    end
    dec_seen[r.dec]++;
    return r;
  endfunction

  // Random reading, shaped after the current filter state. The commonest are
  // small steps and steps right at the threshold. Others jump back near a
  // history entry, which is how a large step gets confirmed. The rest are held
  // spike runs, single spikes and raw noise, out-of-range patterns included.
  function automatic logic [RawW-1:0] next_reading();
    int unsigned     roll;
    int unsigned     lim;
    int              dir;
    logic [RcW-1:0]  nc;
    logic [RawW-1:0] pick;
    nc   = (read_cnt == 5'd31) ? read_cnt : read_cnt + 5'd1;
    lim  = step_limit_x20(nc) / 20;
    roll = $urandom_range(0, 99);
    dir  = ($urandom_range(0, 1) != 0) ? 1 : -1;
    if (burst_left != 0) begin
      burst_left--;
      pick = burst_level;
    end else if (roll < 8) begin
      pick = RawW'($urandom());
    end else if (roll < 12) begin
      case ($urandom_range(0, 3))
        0: begin
          pick = 16'h8000;
        end
        1: begin
          pick = 16'h7FFF;
        end
        2: begin
          pick = 16'hFFFF;
        end
        default: begin
          pick = 16'd25601;
        end
      endcase
    end else if (roll < 50) begin
      pick = clamp_level(int'(last_level) + dir * int'($urandom_range(0, lim)));
    end else if (roll < 58) begin
      pick = clamp_level(int'(last_level) + dir * int'(lim + $urandom_range(0, 1)));
    end else if (roll < 72 && hist_fill != 0) begin
      pick = clamp_level(int'(hist_mem[$urandom_range(0, hist_fill - 1)]) +
                         dir * int'($urandom_range(0, lim + lim / 2)));
    end else if (roll < 82) begin
      burst_level = RawW'($urandom_range(0, 25600));
      burst_left  = $urandom_range(6, 9);
      pick        = burst_level;
    end else begin
      pick = RawW'($urandom_range(0, 25600));
    end
    return pick;
  endfunction

  // Offer one reading and hold it until the block takes the request. The
  // expected result is queued at the edge of acceptance, so the behavioral
  // filter sees the readings in exactly the order the block does.
  task automatic send_reading(input probe_row_t row);
    level_result_t due_now;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_req.valid       <= 1'b1;
    in_req.raw_percent <= row.raw;
    do @(posedge clk_i); while (in_req.ready !== 1'b1);
    due_now = predict_level(row.raw);
    if (row.typed) begin
      due_now.level = row.level;
      due_now.dec   = row.dec;
    end
    pending_levels.push_back(due_now);
    readings_sent++;
  endtask

  // The base threshold changes only while the filter is idle. Every request
  // gives a result, so an empty queue means the pipeline has drained.
  task automatic write_base(input logic [ValW-1:0] v);
    in_req.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    thr_base  = v;
    settings_used++;
  endtask

  // The receiving side holds ready low for random stretches while idling is on.
  always @(posedge clk_i) begin
    if (ready_hold > 1) begin
      ready_hold <= ready_hold - 1;
    end else if (ready_hold == 1) begin
      ready_hold    <= 0;
      out_rsp.ready <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_rsp.ready <= 1'b0;
      ready_hold    <= $urandom_range(1, 18);
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  // The result checker and the watchdog. Values are read at the clock edge,
  // before any update scheduled for that edge takes effect.
  always @(posedge clk_i) begin
    if (out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      if (pending_levels.size() == 0) begin
        $error("result with no reading waiting: filtered_percent %0d decision %0d",
               out_rsp.filtered_percent, out_rsp.decision);
        error_count++;
      end else begin
        due = pending_levels.pop_front();
        if (out_rsp.filtered_percent !== due.level) begin
          $error("filtered_percent: expected %0d, actual %0d", due.level,
                 out_rsp.filtered_percent);
          error_count++;
        end
        if (out_rsp.decision !== due.dec) begin
          $error("decision: expected %0d, actual %0d", due.dec, out_rsp.decision);
          error_count++;
        end
        results_checked++;
      end
    end
    if ((in_req.valid === 1'b1 && in_req.ready === 1'b1) ||
        (out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ValW-1:0] phase_base [NumPhases];
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_req.valid       <= 1'b0;
    in_req.raw_percent <= '0;

    // The threshold settings: both extremes, the smallest nonzero step, a
    // typical value and three random ones. The last setting runs without any
    // stalls.
    phase_base[0] = 15'd0;
    phase_base[1] = 15'd25600;
    phase_base[2] = ValW'($urandom_range(1, 25600));
    phase_base[3] = 15'd1;
    phase_base[4] = 15'd640;
    phase_base[5] = ValW'($urandom_range(0, 25600));
    phase_base[6] = ValW'($urandom_range(200, 3000));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling_on <= 1'b1;

    foreach (probe_rows[i]) begin
      send_reading(probe_rows[i]);
    end

    for (int p = 0; p < NumPhases; p++) begin
      write_base(phase_base[p]);
      for (int k = 0; k < PhaseItems; k++) begin
        // Some stretches run with no stalls at all, and the last setting has
        // none anywhere.
        if (k % 30 == 0) begin
          idling_on <= (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
        end
        send_reading('{next_reading(), 1'b0, 15'd0, DEC_RANGE});
      end
    end

    in_req.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Summary: %0d readings over %0d threshold settings, %0d results checked, %0d %s",
             readings_sent, settings_used, results_checked, error_count, "mismatches");
    $display("Decisions: out of range %0d, first %0d, small step %0d, recalibrated %0d,",
             dec_seen[DEC_RANGE], dec_seen[DEC_FIRST], dec_seen[DEC_SMALL],
             dec_seen[DEC_RECAL]);
    $display("           no history %0d, confirmed %0d, rejected %0d",
             dec_seen[DEC_NO_HIST], dec_seen[DEC_CONFIRM], dec_seen[DEC_REJECT]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
